// File: hw/rtl/adaptive_temporal_accumulator_macros.svh
// Assertion macros for the temporal accumulator.
`ifndef ADAPTIVE_TEMPORAL_ACCUMULATOR_MACROS_SVH
`define ADAPTIVE_TEMPORAL_ACCUMULATOR_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define ATA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// next-cycle implication
`define ATA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

// File: hw/rtl/ata_pkg.sv
// Shared types and constants of the temporal accumulator.
package ata_pkg;

    localparam int COLOR_W = 17;
    localparam int NOISE_W = 12;
    localparam int VAR_W   = 18;
    localparam int DEN_W   = 20;
    localparam int NUM_W   = 36;
    localparam int QUO_W   = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [COLOR_W-1:0] ONE      = 17'd65536;
    localparam logic [COLOR_W-1:0] HALF     = 17'd32768;
    localparam logic [COLOR_W-1:0] GAIN_INS = 17'd42598;
    localparam logic [COLOR_W-1:0] INS_LIM  = 17'd6553;
    localparam logic [COLOR_W-1:0] VAR_SAT  = 17'h1FFFF;

    localparam logic [15:0] LUMA_R   = 16'd13933;
    localparam logic [15:0] LUMA_G   = 16'd46871;
    localparam logic [15:0] LUMA_B   = 16'd4732;
    localparam logic [15:0] NOISE_K  = 16'd3277;
    localparam logic [15:0] MOM_KEEP = 16'd58982;
    localparam logic [15:0] MOM_NEW  = 16'd6554;
    localparam logic [3:0]  NOISE_BASE = 4'd7;
    localparam logic [2:0]  WARM_COUNT = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VAR_FLR  = 2'd2;

    localparam logic [COLOR_W-1:0] RST_GAIN_MIN = 17'd7864;
    localparam logic [COLOR_W-1:0] RST_GAIN_MAX = 17'd55706;
    localparam logic [COLOR_W-1:0] RST_VAR_FLR  = 17'd10;

    typedef struct packed {
        logic [15:0]        pixel_addr;
        logic [COLOR_W-1:0] cur_red;
        logic [COLOR_W-1:0] cur_green;
        logic [COLOR_W-1:0] cur_blue;
        logic               drop_history;
        logic               end_of_frame;
    } t_in_word;

    typedef struct packed {
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
        logic [COLOR_W-1:0] variance_est;
    } t_out_word;

endpackage

// File: hw/rtl/ata_ram.sv
// Generic simple dual-port RAM with registered read.
module ata_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/ata_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module ata_div #(
    parameter int AW      = 16,
    parameter int CARRY_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [ata_pkg::NUM_W-1:0]   i_num,
    input  logic [ata_pkg::DEN_W-1:0]   i_den,
    input  logic [AW-1:0]               i_addr,
    input  logic [CARRY_W-1:0]          i_carry,
    input  logic [AW-1:0]               i_probe,
    output logic                        o_hit,
    output logic                        o_valid,
    output logic [ata_pkg::QUO_W-1:0]   o_quo,
    output logic [AW-1:0]               o_addr,
    output logic [CARRY_W-1:0]          o_carry
);
    import ata_pkg::*;

    logic               w_valid [QUO_W+1];
    logic [NUM_W-1:0]   w_rem   [QUO_W+1];
    logic [DEN_W-1:0]   w_den   [QUO_W+1];
    logic [QUO_W-1:0]   w_quo   [QUO_W+1];
    logic [AW-1:0]      w_addr  [QUO_W+1];
    logic [CARRY_W-1:0] w_carry [QUO_W+1];

    logic               r_valid [QUO_W];
    logic [NUM_W-1:0]   r_rem   [QUO_W];
    logic [DEN_W-1:0]   r_den   [QUO_W];
    logic [QUO_W-1:0]   r_quo   [QUO_W];
    logic [AW-1:0]      r_addr  [QUO_W];
    logic [CARRY_W-1:0] r_carry [QUO_W];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = i_num;
    assign w_den[0]   = i_den;
    assign w_quo[0]   = '0;
    assign w_addr[0]  = i_addr;
    assign w_carry[0] = i_carry;

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        logic [NUM_W-1:0] trial;
        logic             take;

        assign trial = NUM_W'(w_den[i]) << (QUO_W - 1 - i);
        assign take  = (w_rem[i] >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else if (i_en) begin
                r_valid[i] <= w_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]   <= take ? w_rem[i] - trial : w_rem[i];
                r_quo[i]   <= take ? (w_quo[i] | (QUO_W'(1) << (QUO_W - 1 - i))) : w_quo[i];
                r_den[i]   <= w_den[i];
                r_addr[i]  <= w_addr[i];
                r_carry[i] <= w_carry[i];
            end
        end

        assign w_valid[i+1] = r_valid[i];
        assign w_rem[i+1]   = r_rem[i];
        assign w_den[i+1]   = r_den[i];
        assign w_quo[i+1]   = r_quo[i];
        assign w_addr[i+1]  = r_addr[i];
        assign w_carry[i+1] = r_carry[i];
    end

    always_comb begin
        o_hit = 1'b0;
        for (int k = 0; k < QUO_W; k++) begin
            o_hit = o_hit | (r_valid[k] && (r_addr[k] == i_probe));
        end
    end

    assign o_valid = w_valid[QUO_W];
    assign o_quo   = w_quo[QUO_W];
    assign o_addr  = w_addr[QUO_W];
    assign o_carry = w_carry[QUO_W];
endmodule

// File: hw/rtl/adaptive_temporal_accumulator.sv
// A word passes stages Q, R, 1, 2, 3, the divider and 5, then the output register; one word per cycle unless stalled.
// A word whose reduced address matches one still in flight waits at the history-read
// stage until that word is written back (a read-after-write hazard on the history RAM).
// Gain division: 17-stage pipelined restoring divider, one quotient bit per stage.
// Reset: control clears at once, then a pass over every address zeroes the history RAM
// with o_stall high; configuration writes are taken throughout.
module adaptive_temporal_accumulator #(
    parameter int PIXELS      = 65536,
    parameter int HISTORY_CAP = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  ata_pkg::t_in_word                 i_word,
    output logic                              o_valid,
    input  logic                              i_stall,
    output ata_pkg::t_out_word                o_word,
    input  logic                              i_cfg_we,
    input  logic [ata_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ata_pkg::COLOR_W-1:0]       i_cfg_data
);
    import ata_pkg::*;

`include "adaptive_temporal_accumulator_macros.svh"

    localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int CW = $clog2(HISTORY_CAP + 1);
    localparam bit DO_MOD = (PIXELS < 65536);
    localparam logic [32:0] RECIP =
        33'((64'd4294967296 + 64'(PIXELS) - 64'd1) / 64'(PIXELS));

    typedef logic [COLOR_W-1:0] t_col;

    typedef struct packed {
        t_col          red;
        t_col          green;
        t_col          blue;
        t_col          moment;
        logic [CW-1:0] count;
    } t_hist;

    typedef struct packed {
        t_col             cur_r;
        t_col             cur_g;
        t_col             cur_b;
        t_col             old_r;
        t_col             old_g;
        t_col             old_b;
        t_col             moment;
        logic [CW-1:0]    count;
        logic [VAR_W-1:0] variance;
        logic             discard;
        logic             warm;
        logic             boost;
    } t_carry;

    function automatic t_col f_sat(input t_col v);
        return (v > ONE) ? ONE : v;
    endfunction

    function automatic t_col f_luma(input t_col r, input t_col g, input t_col b);
        logic [33:0] s;
        s = 34'(r) * 34'(LUMA_R) + 34'(g) * 34'(LUMA_G) + 34'(b) * 34'(LUMA_B)
            + 34'(HALF);
        return s[32:16];
    endfunction

    function automatic t_col f_absdiff(input t_col a, input t_col b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic t_col f_blend(input t_col old, input t_col cur, input t_col gain);
        logic [33:0] p;
        logic [17:0] d;
        p = 34'(gain) * 34'(f_absdiff(cur, old)) + 34'(HALF);
        d = p[33:16];
        return (cur >= old) ? COLOR_W'(18'(old) + d) : COLOR_W'(18'(old) - d);
    endfunction

    // configuration
    t_col r_gain_min, r_gain_max, r_var_floor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_min  <= RST_GAIN_MIN;
            r_gain_max  <= RST_GAIN_MAX;
            r_var_floor <= RST_VAR_FLR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_MIN: r_gain_min  <= i_cfg_data;
                CFG_GAIN_MAX: r_gain_max  <= i_cfg_data;
                CFG_VAR_FLR:  r_var_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clearing pass
    logic          r_clearing;
    logic [AW-1:0] r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr      <= '0;
        end else if (r_clearing) begin
            r_clr <= r_clr + AW'(1);
            if (r_clr == AW'(PIXELS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    logic r_out_valid;
    t_out_word r_out;
    logic en, en_front, hazard, acc;

    assign en  = !r_out_valid || !i_stall;
    assign acc = i_valid && !o_stall;
    assign o_stall = r_clearing || !en_front;

    // stage Q: capture, quotient for address reduction
    logic        r_hist_ok;
    logic        r_q_valid, r_q_disc;
    logic [15:0] r_q_x, r_q_q;
    t_col        r_q_r, r_q_g, r_q_b;
    logic [48:0] q_prod;

    assign q_prod = 49'(i_word.pixel_addr) * 49'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_hist_ok <= 1'b0;
        end else if (en_front) begin
            r_q_valid <= acc;
            if (acc && i_word.end_of_frame) begin
                r_hist_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_front) begin
            r_q_x    <= i_word.pixel_addr;
            r_q_q    <= DO_MOD ? q_prod[47:32] : 16'd0;
            r_q_r    <= f_sat(i_word.cur_red);
            r_q_g    <= f_sat(i_word.cur_green);
            r_q_b    <= f_sat(i_word.cur_blue);
            r_q_disc <= i_word.drop_history || !r_hist_ok;
        end
    end

    // stage R: reduced address, history read issue
    logic          r_r_valid, r_r_disc;
    logic [AW-1:0] r_r_addr;
    t_col          r_r_r, r_r_g, r_r_b;
    logic [24:0]   addr_rem;

    assign addr_rem = 25'(r_q_x) - 25'(r_q_q) * 25'(PIXELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (en_front) begin
            r_r_valid <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_front) begin
            r_r_addr <= AW'(addr_rem);
            r_r_r    <= r_q_r;
            r_r_g    <= r_q_g;
            r_r_b    <= r_q_b;
            r_r_disc <= r_q_disc;
        end
    end

    // history RAM
    t_hist         ram_rdata, ram_wdata, new_hist;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;

    ata_ram #(.WIDTH($bits(t_hist)), .DEPTH(PIXELS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (en),
        .i_raddr (r_r_addr),
        .o_rdata (ram_rdata)
    );

    // stage 1: read data returns
    logic          r_s1_valid, r_s1_disc;
    logic [AW-1:0] r_s1_addr;
    t_col          r_s1_r, r_s1_g, r_s1_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= r_r_valid && !hazard;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_addr <= r_r_addr;
            r_s1_r    <= r_r_r;
            r_s1_g    <= r_r_g;
            r_s1_b    <= r_r_b;
            r_s1_disc <= r_r_disc;
        end
    end

    // stage 2: lumas
    logic          r_s2_valid, r_s2_disc;
    logic [AW-1:0] r_s2_addr;
    t_col          r_s2_r, r_s2_g, r_s2_b, r_s2_or, r_s2_og, r_s2_ob, r_s2_mom;
    t_col          r_s2_cl, r_s2_ol;
    logic [CW-1:0] r_s2_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_addr <= r_s1_addr;
            r_s2_disc <= r_s1_disc;
            r_s2_r    <= r_s1_r;
            r_s2_g    <= r_s1_g;
            r_s2_b    <= r_s1_b;
            r_s2_or   <= ram_rdata.red;
            r_s2_og   <= ram_rdata.green;
            r_s2_ob   <= ram_rdata.blue;
            r_s2_mom  <= ram_rdata.moment;
            r_s2_cnt  <= ram_rdata.count;
            r_s2_cl   <= f_luma(r_s1_r, r_s1_g, r_s1_b);
            r_s2_ol   <= f_luma(ram_rdata.red, ram_rdata.green, ram_rdata.blue);
        end
    end

    // stage 3: instability, noise, moment update
    logic               r_s3_valid, r_s3_disc, r_s3_warm, r_s3_boost;
    logic [AW-1:0]      r_s3_addr;
    t_col               r_s3_r, r_s3_g, r_s3_b, r_s3_or, r_s3_og, r_s3_ob;
    t_col               r_s3_mom, r_s3_absdm;
    logic [NOISE_W-1:0] r_s3_noise;
    logic [CW-1:0]      r_s3_cnt;
    t_col               instab;
    logic [28:0]        noise_p;
    logic [33:0]        mom_p;

    assign instab  = f_absdiff(r_s2_cl, r_s2_ol);
    assign noise_p = 29'(instab) * 29'(NOISE_K) + 29'(HALF);
    assign mom_p   = 34'(r_s2_mom) * 34'(MOM_KEEP) + 34'(r_s2_cl) * 34'(MOM_NEW)
                     + 34'(HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_addr  <= r_s2_addr;
            r_s3_disc  <= r_s2_disc;
            r_s3_r     <= r_s2_r;
            r_s3_g     <= r_s2_g;
            r_s3_b     <= r_s2_b;
            r_s3_or    <= r_s2_or;
            r_s3_og    <= r_s2_og;
            r_s3_ob    <= r_s2_ob;
            r_s3_noise <= NOISE_W'(noise_p[28:16]) + NOISE_W'(NOISE_BASE);
            r_s3_absdm <= f_absdiff(r_s2_mom, r_s2_ol);
            r_s3_mom   <= mom_p[32:16];
            r_s3_cnt   <= r_s2_disc ? CW'(1)
                        : (r_s2_cnt < CW'(HISTORY_CAP)) ? r_s2_cnt + CW'(1)
                        : CW'(HISTORY_CAP);
            r_s3_warm  <= r_s2_disc || (r_s2_cnt < CW'(WARM_COUNT));
            r_s3_boost <= instab > INS_LIM;
        end
    end

    // variance and divider operands
    logic [VAR_W-1:0] v_sum, variance;
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] num;
    t_carry           s3_carry;

    assign v_sum    = VAR_W'(r_s3_absdm) + VAR_W'(r_s3_noise);
    assign variance = (v_sum < VAR_W'(r_var_floor)) ? VAR_W'(r_var_floor) : v_sum;
    assign den      = (DEN_W'(variance) << 1) + DEN_W'(r_s3_noise);
    assign num      = ((NUM_W'(variance) + NUM_W'(r_s3_noise)) << 16) + NUM_W'(den >> 1);

    always_comb begin
        s3_carry.cur_r    = r_s3_r;
        s3_carry.cur_g    = r_s3_g;
        s3_carry.cur_b    = r_s3_b;
        s3_carry.old_r    = r_s3_or;
        s3_carry.old_g    = r_s3_og;
        s3_carry.old_b    = r_s3_ob;
        s3_carry.moment   = r_s3_mom;
        s3_carry.count    = r_s3_cnt;
        s3_carry.variance = variance;
        s3_carry.discard  = r_s3_disc;
        s3_carry.warm     = r_s3_warm;
        s3_carry.boost    = r_s3_boost;
    end

    logic             div_hit, div_valid;
    logic [QUO_W-1:0] div_quo;
    logic [AW-1:0]    div_addr;
    t_carry           div_carry;

    ata_div #(.AW(AW), .CARRY_W($bits(t_carry))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_valid),
        .i_num   (num),
        .i_den   (den),
        .i_addr  (r_s3_addr),
        .i_carry (s3_carry),
        .i_probe (r_r_addr),
        .o_hit   (div_hit),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_addr  (div_addr),
        .o_carry (div_carry)
    );

    // stage 5: gain shaping
    logic          r_s5_valid;
    logic [AW-1:0] r_s5_addr;
    t_carry        r_s5_c;
    t_col          r_s5_gain, gain;

    always_comb begin
        gain = div_carry.discard ? ONE : div_quo;
        if (gain < r_gain_min) begin
            gain = r_gain_min;
        end else if (gain > r_gain_max) begin
            gain = r_gain_max;
        end
        if (gain > ONE) begin
            gain = ONE;
        end
        if (div_carry.warm && gain < HALF) begin
            gain = HALF;
        end
        if (div_carry.boost && gain < GAIN_INS) begin
            gain = GAIN_INS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (en) begin
            r_s5_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_addr <= div_addr;
            r_s5_c    <= div_carry;
            r_s5_gain <= gain;
        end
    end

    // blend, write-back, output register
    t_col b_or, b_og, b_ob;

    assign b_or = r_s5_c.discard ? r_s5_c.cur_r : r_s5_c.old_r;
    assign b_og = r_s5_c.discard ? r_s5_c.cur_g : r_s5_c.old_g;
    assign b_ob = r_s5_c.discard ? r_s5_c.cur_b : r_s5_c.old_b;

    always_comb begin
        new_hist.red    = f_blend(b_or, r_s5_c.cur_r, r_s5_gain);
        new_hist.green  = f_blend(b_og, r_s5_c.cur_g, r_s5_gain);
        new_hist.blue   = f_blend(b_ob, r_s5_c.cur_b, r_s5_gain);
        new_hist.moment = r_s5_c.moment;
        new_hist.count  = r_s5_c.count;
    end

    assign ram_we    = r_clearing || (en && r_s5_valid);
    assign ram_waddr = r_clearing ? r_clr : r_s5_addr;
    assign ram_wdata = r_clearing ? t_hist'('0) : new_hist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.out_red      <= new_hist.red;
            r_out.out_green    <= new_hist.green;
            r_out.out_blue     <= new_hist.blue;
            r_out.variance_est <= (r_s5_c.variance > VAR_W'(VAR_SAT)) ? VAR_SAT
                                : COLOR_W'(r_s5_c.variance);
        end
    end

    // read-after-write hazard against every word past the read stage and not yet written back
    assign hazard = r_r_valid && (
        (r_s1_valid && r_s1_addr == r_r_addr) ||
        (r_s2_valid && r_s2_addr == r_r_addr) ||
        (r_s3_valid && r_s3_addr == r_r_addr) ||
        div_hit ||
        (r_s5_valid && r_s5_addr == r_r_addr));

    assign en_front = en && !hazard;

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    `ATA_ASSERT_IMP(a_clear_stalls, r_clearing, o_stall)
    `ATA_ASSERT_IMP(a_clear_empty, r_clearing, !r_q_valid && !r_s5_valid)
    `ATA_ASSERT_NXT(a_out_hold, r_out_valid && i_stall, r_out_valid && $stable(r_out))
    `ATA_ASSERT_NXT(a_hazard_hold, hazard && !r_clearing, r_r_valid && $stable(r_r_addr))
endmodule
